### rtl/mfba_pkg.sv
// Shared constants, codes and controller/datapath types of the max-flow unit.
`timescale 1ns / 1ps
package mfba_pkg;

	localparam int MAX_NODES  = 32;
	localparam int NODE_BITS  = $clog2(MAX_NODES);
	localparam int CNT_BITS   = NODE_BITS + 1;
	localparam int ADDR_BITS  = 2 * NODE_BITS;
	localparam int CAP_BITS   = 16;
	localparam int FLOW_BITS  = 17;
	localparam int TOTAL_BITS = 21;
	localparam int NCFG_BITS  = 6;

	// request operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;

	// result status codes
	localparam logic [1:0] ST_WRITE = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLR_ALL,
		DP_CLR_FLOW,
		DP_WRITE,
		DP_READ_ISSUE,
		DP_RUN_INIT,
		DP_BFS_INIT,
		DP_POP,
		DP_SCAN_ISSUE,
		DP_SCAN_EVAL,
		DP_TRACE_INIT,
		DP_TRACE_ISSUE,
		DP_TRACE_EVAL,
		DP_AUG_INIT,
		DP_AUG_ISSUE,
		DP_AUG_FWD,
		DP_AUG_REV,
		DP_ADD_TOTAL
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       load_result;
		logic [1:0] result_status;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic queue_drained;
		logic head_is_sink;
		logic scan_last;
		logic at_source;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/mfba_datapath.sv
// Datapath of the max-flow unit: matrix memories, search queue, parent links and result register.
`timescale 1ns / 1ps
module mfba_datapath
	import mfba_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_status_t                   status,
	input  logic [NCFG_BITS-1:0]         node_count,
	input  logic [NODE_BITS-1:0]         in_from,
	input  logic [NODE_BITS-1:0]         in_to,
	input  logic [CAP_BITS-1:0]          in_capacity,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [1:0]                   out_status,
	output logic [FLOW_BITS-1:0]         out_flow,
	output logic [FLOW_BITS-1:0]         out_residual,
	output logic [TOTAL_BITS-1:0]        out_total
);

	logic [CAP_BITS-1:0]   cap_mem  [MAX_NODES*MAX_NODES];
	logic [FLOW_BITS-1:0]  flow_mem [MAX_NODES*MAX_NODES];
	logic [CAP_BITS-1:0]   cap_rd_q;
	logic [FLOW_BITS-1:0]  flow_rd_q;

	logic [MAX_NODES-1:0]  visited_q;
	logic [NODE_BITS-1:0]  parent_q [MAX_NODES];
	logic [NODE_BITS-1:0]  queue_q  [MAX_NODES];
	logic [CNT_BITS-1:0]   head_q, tail_q;
	logic [NODE_BITS-1:0]  cur_q, j_q, node_q;
	logic [FLOW_BITS-1:0]  least_q, sum_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [ADDR_BITS-1:0]  clr_cnt_q;

	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [FLOW_BITS-1:0]  out_flow_q, out_resid_q;
	logic [TOTAL_BITS-1:0] out_total_q;

	logic [NODE_BITS-1:0]  n_last;
	logic [NODE_BITS-1:0]  row, col, par;
	logic [ADDR_BITS-1:0]  addr;
	logic                  cap_we, flow_we;
	logic [CAP_BITS-1:0]   cap_wd;
	logic [FLOW_BITS-1:0]  flow_wd, flow_new;
	logic signed [FLOW_BITS:0] resid_full;
	logic [FLOW_BITS-1:0]  resid;
	logic                  out_free;

	always_comb begin
		if (node_count < NCFG_BITS'(2))
			n_last = NODE_BITS'(1);
		else if (node_count > NCFG_BITS'(MAX_NODES))
			n_last = NODE_BITS'(MAX_NODES - 1);
		else
			n_last = NODE_BITS'(node_count - NCFG_BITS'(1));
	end

	assign par = parent_q[node_q];

	always_comb begin
		row = par;
		col = node_q;
		unique case (cmd.op)
			DP_CLR_ALL, DP_CLR_FLOW: begin
				row = clr_cnt_q[ADDR_BITS-1:NODE_BITS];
				col = clr_cnt_q[NODE_BITS-1:0];
			end
			DP_WRITE, DP_READ_ISSUE: begin
				row = in_from;
				col = in_to;
			end
			DP_SCAN_ISSUE: begin
				row = cur_q;
				col = j_q;
			end
			DP_AUG_REV: begin
				row = node_q;
				col = par;
			end
			default: begin
				row = par;
				col = node_q;
			end
		endcase
	end

	assign addr       = {row, col};
	assign resid_full = $signed({2'b00, cap_rd_q}) - $signed({flow_rd_q[FLOW_BITS-1], flow_rd_q});
	assign resid      = resid_full[FLOW_BITS-1:0];
	assign flow_new   = flow_rd_q + least_q;

	assign cap_we  = (cmd.op == DP_CLR_ALL) || (cmd.op == DP_WRITE);
	assign cap_wd  = (cmd.op == DP_WRITE) ? in_capacity : '0;
	assign flow_we = (cmd.op == DP_CLR_ALL) || (cmd.op == DP_CLR_FLOW) ||
		(cmd.op == DP_AUG_FWD) || (cmd.op == DP_AUG_REV);

	always_comb begin
		unique case (cmd.op)
			DP_AUG_FWD: flow_wd = flow_new;
			DP_AUG_REV: flow_wd = FLOW_BITS'(-sum_q);
			default:    flow_wd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cap_we)
			cap_mem[addr] <= cap_wd;
		cap_rd_q <= cap_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (flow_we)
			flow_mem[addr] <= flow_wd;
		flow_rd_q <= flow_mem[addr];
	end

	// queue and parent links are always written before they are read
	always_ff @(posedge clk) begin
		if (cmd.op == DP_BFS_INIT)
			queue_q[0] <= '0;
		else if (cmd.op == DP_SCAN_EVAL && resid_full != '0 && !visited_q[j_q]) begin
			queue_q[tail_q[NODE_BITS-1:0]] <= j_q;
			parent_q[j_q] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			cur_q     <= '0;
			j_q       <= '0;
			node_q    <= '0;
			least_q   <= '0;
			sum_q     <= '0;
			total_q   <= '0;
			clr_cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				DP_CLR_ALL, DP_CLR_FLOW: clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
				DP_RUN_INIT: begin
					clr_cnt_q <= '0;
					total_q   <= '0;
				end
				DP_BFS_INIT: begin
					visited_q    <= MAX_NODES'(1);
					head_q       <= '0;
					tail_q       <= CNT_BITS'(1);
				end
				DP_POP: begin
					cur_q  <= queue_q[head_q[NODE_BITS-1:0]];
					head_q <= head_q + CNT_BITS'(1);
					j_q    <= '0;
				end
				DP_SCAN_EVAL: begin
					if (resid_full != '0 && !visited_q[j_q]) begin
						visited_q[j_q] <= 1'b1;
						tail_q         <= tail_q + CNT_BITS'(1);
					end
					j_q <= j_q + NODE_BITS'(1);
				end
				DP_TRACE_INIT: begin
					node_q  <= NODE_BITS'(1);
					least_q <= '1;
				end
				DP_TRACE_EVAL: begin
					if (resid < least_q)
						least_q <= resid;
					node_q <= par;
				end
				DP_AUG_INIT: node_q <= NODE_BITS'(1);
				DP_AUG_FWD:  sum_q  <= flow_new;
				DP_AUG_REV:  node_q <= par;
				DP_ADD_TOTAL: total_q <= total_q + TOTAL_BITS'(least_q);
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_result)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_status_q <= cmd.result_status;
			out_flow_q   <= (cmd.result_status == ST_READ) ? flow_rd_q : '0;
			out_resid_q  <= (cmd.result_status == ST_READ) ? resid : '0;
			out_total_q  <= total_q;
		end
	end

	assign status.clr_last      = &clr_cnt_q;
	assign status.queue_drained = (head_q == tail_q);
	assign status.head_is_sink  = (queue_q[head_q[NODE_BITS-1:0]] == NODE_BITS'(1));
	assign status.scan_last     = (j_q == n_last);
	assign status.at_source     = (node_q == '0);
	assign status.out_free      = out_free;

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_flow     = out_flow_q;
	assign out_residual = out_resid_q;
	assign out_total    = out_total_q;

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("search queue read past its tail");
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CNT_BITS'(MAX_NODES)) else $error("search queue overrun");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> out_free) else $error("result overwritten before taken");

endmodule

### rtl/mfba_ctrl.sv
// Controller state machine of the max-flow unit: sequences clearing, search, trace and augment.
`timescale 1ns / 1ps
module mfba_ctrl
	import mfba_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_op,
	output logic       req_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_RUN_CLR,
		S_BFS_INIT,
		S_POP,
		S_SCAN_ISSUE,
		S_SCAN_EVAL,
		S_TRACE_ISSUE,
		S_TRACE_EVAL,
		S_AUG_ISSUE,
		S_AUG_FWD,
		S_AUG_REV,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == S_IDLE) && status.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d           = state_q;
		cmd.op            = DP_NOP;
		cmd.load_result   = 1'b0;
		cmd.result_status = ST_WRITE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = DP_CLR_ALL;
				if (status.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					priority if (req_op == OP_WRITE) begin
						cmd.op            = DP_WRITE;
						cmd.load_result   = 1'b1;
						cmd.result_status = ST_WRITE;
					end else if (req_op == OP_RUN) begin
						cmd.op  = DP_RUN_INIT;
						state_d = S_RUN_CLR;
					end else begin
						cmd.op  = DP_READ_ISSUE;
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.load_result   = 1'b1;
				cmd.result_status = ST_READ;
				state_d           = S_IDLE;
			end
			S_RUN_CLR: begin
				cmd.op = DP_CLR_FLOW;
				if (status.clr_last)
					state_d = S_BFS_INIT;
			end
			S_BFS_INIT: begin
				cmd.op  = DP_BFS_INIT;
				state_d = S_POP;
			end
			S_POP: begin
				priority if (status.queue_drained)
					state_d = S_RESULT;
				else if (status.head_is_sink) begin
					cmd.op  = DP_TRACE_INIT;
					state_d = S_TRACE_ISSUE;
				end else begin
					cmd.op  = DP_POP;
					state_d = S_SCAN_ISSUE;
				end
			end
			S_SCAN_ISSUE: begin
				cmd.op  = DP_SCAN_ISSUE;
				state_d = S_SCAN_EVAL;
			end
			S_SCAN_EVAL: begin
				cmd.op  = DP_SCAN_EVAL;
				state_d = status.scan_last ? S_POP : S_SCAN_ISSUE;
			end
			S_TRACE_ISSUE: begin
				if (status.at_source) begin
					cmd.op  = DP_AUG_INIT;
					state_d = S_AUG_ISSUE;
				end else begin
					cmd.op  = DP_TRACE_ISSUE;
					state_d = S_TRACE_EVAL;
				end
			end
			S_TRACE_EVAL: begin
				cmd.op  = DP_TRACE_EVAL;
				state_d = S_TRACE_ISSUE;
			end
			S_AUG_ISSUE: begin
				if (status.at_source) begin
					cmd.op  = DP_ADD_TOTAL;
					state_d = S_BFS_INIT;
				end else begin
					cmd.op  = DP_AUG_ISSUE;
					state_d = S_AUG_FWD;
				end
			end
			S_AUG_FWD: begin
				cmd.op  = DP_AUG_FWD;
				state_d = S_AUG_REV;
			end
			S_AUG_REV: begin
				cmd.op  = DP_AUG_REV;
				state_d = S_AUG_ISSUE;
			end
			S_RESULT: begin
				// hold until the result register is free
				if (status.out_free) begin
					cmd.load_result   = 1'b1;
					cmd.result_status = ST_RUN;
					state_d           = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

### rtl/max_flow_bfs_augment_unit.sv
// Top level of the max-flow unit: stream ports, node count register and block wiring.
//
// Requests arrive on the s_ channel (tvalid/tready/tdata): write a capacity entry, run
// max flow from node 0 to node 1, or read the flow and residual of one entry. Each request
// yields exactly one result on the m_ channel, held in an output register until taken.
// node_count is set over the APB-style port at byte address 0; the user must set it only
// while the unit is idle, as the block itself does not enforce this. A write request
// completes in the accepting cycle, which also registers its result; a read issues its
// memory access when accepted and loads its result in the S_READ state. A run first
// clears the 1024-entry flow memory, then repeats a breadth-first search over the n
// active nodes, in which every matrix entry goes through the memory read ports in an
// issue and an evaluate step; each augmenting path is then traced and augmented
// edge by edge. After reset the unit sweeps both matrix memories to zero, one entry a
// cycle, and takes no request until done; configuration writes are taken throughout.
// A stalled receiver holds the result; no new request is taken until the output
// register is free or being emptied in the same cycle.
`timescale 1ns / 1ps
module max_flow_bfs_augment_unit
	import mfba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // operation[1:0], from_node[6:2], to_node[11:7], capacity[27:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // status[1:0], flow_value[18:2], residual_value[35:19], total_flow[56:36]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [NCFG_BITS-1:0]  node_count_q;
	dp_cmd_t               cmd;
	dp_status_t            status;
	logic [1:0]            out_status;
	logic [FLOW_BITS-1:0]  out_flow, out_residual;
	logic [TOTAL_BITS-1:0] out_total;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {26'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= NCFG_BITS'(2);
		else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
			node_count_q <= pwdata[NCFG_BITS-1:0];
	end

	mfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_op    (s_tdata[1:0]),
		.req_ready (s_tready),
		.status    (status),
		.cmd       (cmd)
	);

	mfba_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.node_count   (node_count_q),
		.in_from      (s_tdata[6:2]),
		.in_to        (s_tdata[11:7]),
		.in_capacity  (s_tdata[27:12]),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_status   (out_status),
		.out_flow     (out_flow),
		.out_residual (out_residual),
		.out_total    (out_total)
	);

	assign m_tdata = {7'd0, out_total, out_residual, out_flow, out_status};

endmodule
